### rtl/ibm_pkg.sv
// ---------------------------------------------------------------------------
// ibm_pkg
// Shared constants, codes, types and helpers of the inode block map allocator.
// ---------------------------------------------------------------------------
package ibm_pkg;

    localparam int DIRECT_PTRS     = 12;
    localparam int PTRS_PER_BLOCK  = 16;
    localparam int FREE_PTRS       = 15;
    localparam int INODES_PER_META = 4;
    localparam int DISK_BLOCKS_MAX = 1024;
    localparam int INODES_MAX      = 256;
    localparam int SLOTS_PER_INODE = DIRECT_PTRS + 3;

    localparam int BLK_W   = 10;
    localparam int LINK_W  = 11;
    localparam int DIGIT_W = 4;
    localparam int REL_W   = 3 * DIGIT_W;
    localparam int OFF_W   = 13;
    localparam int SZ_W    = 13;
    localparam int INO_W   = 8;
    localparam int FOFF_W  = 5;
    localparam int IBLK_W  = 7;
    localparam int IP_AW   = 12;
    localparam int PS_AW   = BLK_W + DIGIT_W;
    localparam int IP_DEPTH = INODES_MAX * SLOTS_PER_INODE;
    localparam int PS_DEPTH = DISK_BLOCKS_MAX * PTRS_PER_BLOCK;

    // Region limits of the logical index space
    localparam int LIM1 = DIRECT_PTRS + PTRS_PER_BLOCK;
    localparam int LIM2 = LIM1 + PTRS_PER_BLOCK * PTRS_PER_BLOCK;
    localparam int LIM3 = LIM2 + PTRS_PER_BLOCK * PTRS_PER_BLOCK * PTRS_PER_BLOCK;

    localparam logic [LINK_W-1:0] NIL_BLOCK = LINK_W'(DISK_BLOCKS_MAX);

    typedef enum logic [1:0] {
        ACT_READ, ACT_WRITE, ACT_TRUNC, ACT_FORMAT
    } t_action;

    typedef enum logic [1:0] {
        ST_OK, ST_BEYOND, ST_BAD_INODE, ST_NO_SPACE
    } t_status;

    typedef enum logic {
        REG_DISK_BLOCKS, REG_INODE_COUNT
    } t_reg_idx;

    typedef struct packed {
        logic [10:0] disk_blocks;
        logic [8:0]  inode_count;
    } t_cfg;

    typedef struct packed {
        logic [BLK_W-1:0] phys;
        t_status          status;
        logic [SZ_W-1:0]  fblocks;
    } t_result;

    typedef struct packed {
        logic             beyond;
        logic [1:0]       depth;
        logic [REL_W-1:0] rel;
    } t_region;

    function automatic t_region region_of(input logic [OFF_W-1:0] off);
        t_region rg;
        rg.beyond = 1'b0;
        rg.depth  = 2'd0;
        rg.rel    = REL_W'(off);
        if (off < OFF_W'(DIRECT_PTRS)) begin
            rg.depth = 2'd0;
        end else if (off < OFF_W'(LIM1)) begin
            rg.depth = 2'd1;
            rg.rel   = REL_W'(off - OFF_W'(DIRECT_PTRS));
        end else if (off < OFF_W'(LIM2)) begin
            rg.depth = 2'd2;
            rg.rel   = REL_W'(off - OFF_W'(LIM1));
        end else if (off < OFF_W'(LIM3)) begin
            rg.depth = 2'd3;
            rg.rel   = REL_W'(off - OFF_W'(LIM2));
        end else begin
            rg.beyond = 1'b1;
        end
        return rg;
    endfunction

    // Digit k (base PTRS_PER_BLOCK) of a relative index
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [REL_W-1:0] rel,
                                                    input logic [1:0] k);
        logic [REL_W-1:0] sh;
        sh = rel >> {k, 2'b00};
        return sh[DIGIT_W-1:0];
    endfunction

    // Mask of the n lowest digits
    function automatic logic [REL_W-1:0] low_mask(input logic [1:0] n);
        logic [REL_W-1:0] one;
        one = REL_W'(1);
        return (one << {n, 2'b00}) - one;
    endfunction

endpackage

### rtl/ibm_ram.sv
// ---------------------------------------------------------------------------
// ibm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ibm_ram #(
    parameter int WIDTH  = 10,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ibm_regs.sv
// ---------------------------------------------------------------------------
// ibm_regs
// APB configuration registers: disk size and inode count.
// ---------------------------------------------------------------------------
module ibm_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ibm_pkg::t_cfg o_cfg
);

    ibm_pkg::t_cfg    r_cfg;
    ibm_pkg::t_reg_idx idx;

    assign idx    = ibm_pkg::t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.disk_blocks <= 11'd1024;
            r_cfg.inode_count <= 9'd16;
        end else if (psel && penable && pwrite) begin
            case (idx)
                ibm_pkg::REG_DISK_BLOCKS: r_cfg.disk_blocks <= pwdata[10:0];
                ibm_pkg::REG_INODE_COUNT: r_cfg.inode_count <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            ibm_pkg::REG_DISK_BLOCKS: prdata = {21'd0, r_cfg.disk_blocks};
            ibm_pkg::REG_INODE_COUNT: prdata = {23'd0, r_cfg.inode_count};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/ibm_ctrl.sv
// ---------------------------------------------------------------------------
// ibm_ctrl
// Request sequencer: walks and updates the pointer, link and size memories.
// ---------------------------------------------------------------------------
module ibm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ibm_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_action,
    input  logic [ibm_pkg::INO_W-1:0]   i_inode,
    input  logic [ibm_pkg::OFF_W-1:0]   i_offset,
    input  logic                        i_out_free,
    output logic                        o_res_valid,
    output ibm_pkg::t_result            o_res
);

    typedef enum logic [4:0] {
        S_IDLE, S_SIZE, S_DISP, S_F_INIT, S_F_FILL,
        S_A_START, S_A_ROOT, S_A_LV, S_A_PSRD, S_POP, S_POP_WAIT, S_A_NEXT,
        S_MAP, S_M_RD, S_M_LV, S_M_PSRD,
        S_T_START, S_T_DRD, S_T_RD, S_T_LV, S_T_PSRD, S_T_UP, S_T_NEXT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {P_DIRECT, P_ROOT, P_MID, P_LEAF} t_pop;

    localparam int BW = ibm_pkg::BLK_W;
    localparam int LW = ibm_pkg::LINK_W;

    t_state                      r_state, n_state;
    ibm_pkg::t_action            r_act, n_act;
    logic [ibm_pkg::INO_W-1:0]   r_ino, n_ino;
    logic [ibm_pkg::OFF_W-1:0]   r_off, n_off;
    logic [ibm_pkg::SZ_W-1:0]    r_size, n_size;
    ibm_pkg::t_status            r_status, n_status;
    logic [BW-1:0]               r_phys, n_phys;
    logic [LW-1:0]               r_head, n_head, r_save_head, n_save_head;
    logic [ibm_pkg::FOFF_W-1:0]  r_foff, n_foff, r_save_foff, n_save_foff;
    logic [ibm_pkg::IBLK_W-1:0]  r_iblk, n_iblk;
    logic [ibm_pkg::IP_AW-1:0]   r_base, n_base;
    logic [ibm_pkg::OFF_W-1:0]   r_i, n_i;
    logic [1:0]                  r_d, n_d, r_lv, n_lv;
    logic [ibm_pkg::REL_W-1:0]   r_rel, n_rel;
    logic [BW-1:0]               r_node, n_node, r_nb, n_nb;
    logic [BW-1:0]               r_nodes [4];
    logic [BW-1:0]               n_nodes [4];
    t_pop                        r_pop, n_pop;
    logic                        r_from_link, n_from_link;
    logic [BW-1:0]               r_g, n_g;
    logic [3:0]                  r_j, n_j, r_cnt, n_cnt;
    logic [LW-1:0]               r_next, n_next, r_nd, n_nd;

    logic                        r_vld [ibm_pkg::INODES_MAX];
    logic                        r_vld_q;
    logic                        vld_set, vld_clr;

    // memory ports
    logic                        sz_we;
    logic [ibm_pkg::SZ_W-1:0]    sz_wdata, sz_rdata;
    logic                        ip_we;
    logic [ibm_pkg::IP_AW-1:0]   ip_waddr, ip_raddr;
    logic [BW-1:0]               ip_wdata, ip_rdata;
    logic                        ps_we;
    logic [ibm_pkg::PS_AW-1:0]   ps_waddr, ps_raddr;
    logic [BW-1:0]               ps_wdata, ps_rdata;
    logic                        lk_we;
    logic [BW-1:0]               lk_waddr, lk_raddr;
    logic [LW-1:0]               lk_wdata, lk_rdata;

    logic                        push_en;
    logic [BW-1:0]               push_blk;
    ibm_pkg::t_region            rg_i, rg_off;
    logic [1:0]                  k;
    logic [ibm_pkg::DIGIT_W-1:0] dig;
    logic                        ino_ok;
    logic [BW-1:0]               nb_val, phys_ofs;
    logic [8:0]                  ic;
    logic [9:0]                  ic_sum;
    logic [ibm_pkg::IBLK_W-1:0]  nib;
    logic [LW-1:0]               db, nd;
    logic [4:0]                  grp_r;
    logic [1:0]                  up_n;
    logic [ibm_pkg::REL_W-1:0]   up_mask;

    ibm_ram #(.WIDTH(ibm_pkg::SZ_W), .DEPTH(ibm_pkg::INODES_MAX)) u_size (
        .i_clk(i_clk), .i_we(sz_we), .i_waddr(r_ino), .i_wdata(sz_wdata),
        .i_raddr(i_inode), .o_rdata(sz_rdata)
    );
    ibm_ram #(.WIDTH(BW), .DEPTH(ibm_pkg::IP_DEPTH), .ADDR_W(ibm_pkg::IP_AW)) u_iptr (
        .i_clk(i_clk), .i_we(ip_we), .i_waddr(ip_waddr), .i_wdata(ip_wdata),
        .i_raddr(ip_raddr), .o_rdata(ip_rdata)
    );
    ibm_ram #(.WIDTH(BW), .DEPTH(ibm_pkg::PS_DEPTH)) u_ps (
        .i_clk(i_clk), .i_we(ps_we), .i_waddr(ps_waddr), .i_wdata(ps_wdata),
        .i_raddr(ps_raddr), .o_rdata(ps_rdata)
    );
    ibm_ram #(.WIDTH(LW), .DEPTH(ibm_pkg::DISK_BLOCKS_MAX)) u_link (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_raddr(lk_raddr), .o_rdata(lk_rdata)
    );

    assign rg_i     = ibm_pkg::region_of(r_i);
    assign rg_off   = ibm_pkg::region_of(r_off);
    assign k        = r_d - 2'd1 - r_lv;
    assign dig      = ibm_pkg::digit_of(r_rel, k);
    assign ino_ok   = {1'b0, r_ino} < {r_iblk, 2'b00};
    assign phys_ofs = BW'(r_iblk) + BW'(1);
    assign nb_val   = r_from_link ? r_nb : ps_rdata;
    assign up_n     = r_d - r_lv;
    assign up_mask  = ibm_pkg::low_mask(up_n);
    assign o_ready  = (r_state == S_IDLE);

    // format geometry
    always_comb begin
        ic = i_cfg.inode_count;
        if (ic == 9'd0) begin
            ic = 9'd1;
        end else if (ic > 9'(ibm_pkg::INODES_MAX)) begin
            ic = 9'(ibm_pkg::INODES_MAX);
        end
        ic_sum = {1'b0, ic} + 10'(ibm_pkg::INODES_PER_META - 1);
        nib    = ibm_pkg::IBLK_W'(ic_sum >> 2);
        db     = (i_cfg.disk_blocks > ibm_pkg::NIL_BLOCK) ? ibm_pkg::NIL_BLOCK
                                                          : i_cfg.disk_blocks;
        nd     = (db > LW'(nib) + LW'(1)) ? db - LW'(nib) - LW'(1) : LW'(0);
        grp_r  = (nd[3:0] == 4'd0) ? 5'd16 : {1'b0, nd[3:0]};
    end

    always_comb begin
        n_state = r_state;  n_act = r_act;  n_ino = r_ino;  n_off = r_off;
        n_size = r_size;  n_status = r_status;  n_phys = r_phys;
        n_head = r_head;  n_foff = r_foff;  n_save_head = r_save_head;
        n_save_foff = r_save_foff;  n_iblk = r_iblk;  n_base = r_base;
        n_i = r_i;  n_d = r_d;  n_lv = r_lv;  n_rel = r_rel;  n_node = r_node;
        n_nb = r_nb;  n_nodes = r_nodes;  n_pop = r_pop;  n_from_link = r_from_link;
        n_g = r_g;  n_j = r_j;  n_cnt = r_cnt;  n_next = r_next;  n_nd = r_nd;
        sz_we = 1'b0;  sz_wdata = '0;
        ip_we = 1'b0;  ip_waddr = '0;  ip_wdata = '0;  ip_raddr = '0;
        ps_we = 1'b0;  ps_waddr = '0;  ps_wdata = '0;  ps_raddr = '0;
        lk_we = 1'b0;  lk_waddr = '0;  lk_wdata = '0;  lk_raddr = '0;
        push_en = 1'b0;  push_blk = '0;
        vld_set = 1'b0;  vld_clr = 1'b0;
        o_res_valid = 1'b0;
        o_res.phys = r_phys;
        o_res.status = r_status;
        o_res.fblocks = ino_ok ? r_size : '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act = ibm_pkg::t_action'(i_action);
                    n_ino = i_inode;
                    n_off = i_offset;
                    n_status = ibm_pkg::ST_OK;
                    n_phys = '0;
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                n_size = r_vld_q ? sz_rdata : '0;
                n_base = ({r_ino, 4'b0000} - {4'b0000, r_ino});
                n_state = S_DISP;
            end
            S_DISP: begin
                n_state = S_DONE;
                if (r_act == ibm_pkg::ACT_FORMAT) begin
                    if (r_iblk == '0) begin
                        n_state = S_F_INIT;
                    end
                end else if (!ino_ok) begin
                    n_status = ibm_pkg::ST_BAD_INODE;
                end else begin
                    case (r_act)
                        ibm_pkg::ACT_READ: begin
                            if (r_off >= r_size) begin
                                n_status = ibm_pkg::ST_BEYOND;
                            end else begin
                                n_state = S_MAP;
                            end
                        end
                        ibm_pkg::ACT_WRITE: begin
                            if (rg_off.beyond) begin
                                n_status = ibm_pkg::ST_BEYOND;
                            end else if (r_off >= r_size) begin
                                n_save_head = r_head;
                                n_save_foff = r_foff;
                                n_i = r_size;
                                n_state = S_A_START;
                            end else begin
                                n_state = S_MAP;
                            end
                        end
                        default: begin
                            if (r_size != '0) begin
                                n_i = '0;
                                n_state = S_T_START;
                            end
                        end
                    endcase
                end
            end
            S_F_INIT: begin
                n_iblk = nib;
                n_size = '0;
                vld_clr = 1'b1;
                if (nd == '0) begin
                    n_head = ibm_pkg::NIL_BLOCK;
                    n_foff = ibm_pkg::FOFF_W'(ibm_pkg::FREE_PTRS);
                    n_state = S_DONE;
                end else begin
                    n_head = '0;
                    n_foff = grp_r - 5'd1;
                    n_g = '0;
                    n_j = '0;
                    n_cnt = 4'(grp_r - 5'd1);
                    n_next = LW'(grp_r);
                    n_nd = nd;
                    n_state = S_F_FILL;
                end
            end
            S_F_FILL: begin
                if (r_j < r_cnt) begin
                    ps_we = 1'b1;
                    ps_waddr = {r_g, r_j};
                    ps_wdata = r_g + BW'(r_j) + BW'(1);
                    n_j = r_j + 4'd1;
                end else begin
                    lk_we = 1'b1;
                    lk_waddr = r_g;
                    lk_wdata = (r_next < r_nd) ? r_next : ibm_pkg::NIL_BLOCK;
                    if (r_next < r_nd) begin
                        n_g = BW'(r_next);
                        n_next = r_next + LW'(ibm_pkg::PTRS_PER_BLOCK);
                        n_j = '0;
                        n_cnt = 4'(ibm_pkg::FREE_PTRS);
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_A_START: begin
                n_d = rg_i.depth;
                n_rel = rg_i.rel;
                n_lv = '0;
                ip_raddr = r_base + ibm_pkg::IP_AW'(ibm_pkg::DIRECT_PTRS - 1)
                         + ibm_pkg::IP_AW'(rg_i.depth);
                if (rg_i.depth == 2'd0) begin
                    n_pop = P_DIRECT;
                    n_state = S_POP;
                end else if (rg_i.rel == '0) begin
                    n_pop = P_ROOT;
                    n_state = S_POP;
                end else begin
                    n_state = S_A_ROOT;
                end
            end
            S_A_ROOT: begin
                n_node = ip_rdata;
                n_state = S_A_LV;
            end
            S_A_LV: begin
                ps_raddr = {r_node, dig};
                if ({1'b0, r_lv} + 3'd1 < {1'b0, r_d}) begin
                    if ((r_rel & ibm_pkg::low_mask(k)) == '0) begin
                        n_pop = P_MID;
                        n_state = S_POP;
                    end else begin
                        n_state = S_A_PSRD;
                    end
                end else begin
                    n_pop = P_LEAF;
                    n_state = S_POP;
                end
            end
            S_A_PSRD: begin
                n_node = ps_rdata;
                n_lv = r_lv + 2'd1;
                n_state = S_A_LV;
            end
            S_POP: begin
                if (r_head >= ibm_pkg::NIL_BLOCK) begin
                    // out of space: roll the list back
                    n_head = r_save_head;
                    n_foff = r_save_foff;
                    n_status = ibm_pkg::ST_NO_SPACE;
                    n_state = S_DONE;
                end else if (r_foff != '0) begin
                    ps_raddr = {r_head[BW-1:0], 4'(r_foff - 5'd1)};
                    n_foff = r_foff - 5'd1;
                    n_from_link = 1'b0;
                    n_state = S_POP_WAIT;
                end else begin
                    lk_raddr = r_head[BW-1:0];
                    n_nb = r_head[BW-1:0];
                    n_foff = ibm_pkg::FOFF_W'(ibm_pkg::FREE_PTRS);
                    n_from_link = 1'b1;
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                if (r_from_link) begin
                    n_head = lk_rdata;
                end
                case (r_pop)
                    P_DIRECT: begin
                        ip_we = 1'b1;
                        ip_waddr = r_base + r_rel;
                        ip_wdata = nb_val;
                        n_state = S_A_NEXT;
                    end
                    P_ROOT: begin
                        ip_we = 1'b1;
                        ip_waddr = r_base + ibm_pkg::IP_AW'(ibm_pkg::DIRECT_PTRS - 1)
                                 + ibm_pkg::IP_AW'(r_d);
                        ip_wdata = nb_val;
                        n_node = nb_val;
                        n_state = S_A_LV;
                    end
                    P_MID: begin
                        ps_we = 1'b1;
                        ps_waddr = {r_node, dig};
                        ps_wdata = nb_val;
                        n_node = nb_val;
                        n_lv = r_lv + 2'd1;
                        n_state = S_A_LV;
                    end
                    default: begin
                        ps_we = 1'b1;
                        ps_waddr = {r_node, dig};
                        ps_wdata = nb_val;
                        n_state = S_A_NEXT;
                    end
                endcase
            end
            S_A_NEXT: begin
                if (r_i == r_off) begin
                    sz_we = 1'b1;
                    sz_wdata = r_off + ibm_pkg::SZ_W'(1);
                    vld_set = 1'b1;
                    n_size = r_off + ibm_pkg::SZ_W'(1);
                    n_state = S_MAP;
                end else begin
                    n_i = r_i + ibm_pkg::OFF_W'(1);
                    n_state = S_A_START;
                end
            end
            S_MAP: begin
                n_d = rg_off.depth;
                n_rel = rg_off.rel;
                n_lv = '0;
                if (rg_off.depth == 2'd0) begin
                    ip_raddr = r_base + rg_off.rel;
                end else begin
                    ip_raddr = r_base + ibm_pkg::IP_AW'(ibm_pkg::DIRECT_PTRS - 1)
                             + ibm_pkg::IP_AW'(rg_off.depth);
                end
                n_state = S_M_RD;
            end
            S_M_RD: begin
                n_node = ip_rdata;
                if (r_d == 2'd0) begin
                    n_phys = ip_rdata + phys_ofs;
                    n_state = S_DONE;
                end else begin
                    n_state = S_M_LV;
                end
            end
            S_M_LV: begin
                ps_raddr = {r_node, dig};
                n_state = S_M_PSRD;
            end
            S_M_PSRD: begin
                n_node = ps_rdata;
                if (r_lv + 2'd1 == r_d) begin
                    n_phys = ps_rdata + phys_ofs;
                    n_state = S_DONE;
                end else begin
                    n_lv = r_lv + 2'd1;
                    n_state = S_M_LV;
                end
            end
            S_T_START: begin
                n_d = rg_i.depth;
                n_rel = rg_i.rel;
                n_lv = '0;
                if (rg_i.depth == 2'd0) begin
                    ip_raddr = r_base + rg_i.rel;
                    n_state = S_T_DRD;
                end else begin
                    ip_raddr = r_base + ibm_pkg::IP_AW'(ibm_pkg::DIRECT_PTRS - 1)
                             + ibm_pkg::IP_AW'(rg_i.depth);
                    n_state = S_T_RD;
                end
            end
            S_T_DRD: begin
                push_en = 1'b1;
                push_blk = ip_rdata;
                n_state = S_T_NEXT;
            end
            S_T_RD: begin
                n_nodes[0] = ip_rdata;
                n_state = S_T_LV;
            end
            S_T_LV: begin
                ps_raddr = {r_nodes[r_lv], dig};
                n_state = S_T_PSRD;
            end
            S_T_PSRD: begin
                n_nodes[r_lv + 2'd1] = ps_rdata;
                if (r_lv + 2'd1 == r_d) begin
                    push_en = 1'b1;
                    push_blk = ps_rdata;
                    n_state = S_T_UP;
                end else begin
                    n_lv = r_lv + 2'd1;
                    n_state = S_T_LV;
                end
            end
            S_T_UP: begin
                // free an indirect block once its last slot is released
                if ((r_rel & up_mask) != up_mask && r_i + ibm_pkg::OFF_W'(1) != r_size) begin
                    n_state = S_T_NEXT;
                end else begin
                    push_en = 1'b1;
                    push_blk = r_nodes[r_lv];
                    if (r_lv == 2'd0) begin
                        n_state = S_T_NEXT;
                    end else begin
                        n_lv = r_lv - 2'd1;
                    end
                end
            end
            S_T_NEXT: begin
                if (r_i + ibm_pkg::OFF_W'(1) == r_size) begin
                    sz_we = 1'b1;
                    sz_wdata = '0;
                    vld_set = 1'b1;
                    n_size = '0;
                    n_state = S_DONE;
                end else begin
                    n_i = r_i + ibm_pkg::OFF_W'(1);
                    n_state = S_T_START;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // free-list push: into the head block, or the block becomes the head
        if (push_en) begin
            if (r_head < ibm_pkg::NIL_BLOCK
                    && r_foff < ibm_pkg::FOFF_W'(ibm_pkg::FREE_PTRS)) begin
                ps_we = 1'b1;
                ps_waddr = {r_head[BW-1:0], r_foff[3:0]};
                ps_wdata = push_blk;
                n_foff = r_foff + 5'd1;
            end else begin
                lk_we = 1'b1;
                lk_waddr = push_blk;
                lk_wdata = r_head;
                n_head = {1'b0, push_blk};
                n_foff = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= ibm_pkg::NIL_BLOCK;
            r_foff  <= '0;
            r_iblk  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_foff  <= n_foff;
            r_iblk  <= n_iblk;
        end
        r_act <= n_act;  r_ino <= n_ino;  r_off <= n_off;  r_size <= n_size;
        r_status <= n_status;  r_phys <= n_phys;  r_save_head <= n_save_head;
        r_save_foff <= n_save_foff;  r_base <= n_base;  r_i <= n_i;  r_d <= n_d;
        r_lv <= n_lv;  r_rel <= n_rel;  r_node <= n_node;  r_nb <= n_nb;
        r_nodes <= n_nodes;  r_pop <= n_pop;  r_from_link <= n_from_link;
        r_g <= n_g;  r_j <= n_j;  r_cnt <= n_cnt;  r_next <= n_next;  r_nd <= n_nd;
    end

    // size valid bits: an inode never written since reset or format reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || vld_clr) begin
            for (int n = 0; n < ibm_pkg::INODES_MAX; n++) begin
                r_vld[n] <= 1'b0;
            end
        end else if (vld_set) begin
            r_vld[r_ino] <= 1'b1;
        end
        r_vld_q <= r_vld[i_inode];
    end

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP_WAIT |-> $past(r_head) != ibm_pkg::NIL_BLOCK)
        else $error("pop taken from an empty free list");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> r_state == S_SIZE)
        else $error("accepted request not started");

    a_fail_no_phys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ibm_pkg::ST_OK) |-> o_res.phys == '0)
        else $error("failed request carries a block number");

    a_format_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_F_INIT |=> r_iblk != '0)
        else $error("format left the store unformatted");

endmodule

### rtl/inode_block_map_allocator_unit.sv
// ---------------------------------------------------------------------------
// inode_block_map_allocator_unit
// Unix-style inode block map with chained free list over one block store.
// ---------------------------------------------------------------------------
// Request to result: a read map follows the pointers of each indirect level; a write
//   map allocates any missing block up to the offset and then walks the map; truncate
//   frees every block held; format lays out the free-list groups.
// Flow: one request in flight; the next request can be taken in the cycle after
//   the result is handed to the output register.
// Reset: control, free-list head and inode sizes clear at once (size valid bits).
module inode_block_map_allocator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // request channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_action,
    input  logic [ibm_pkg::INO_W-1:0]   i_inode,
    input  logic [ibm_pkg::OFF_W-1:0]   i_offset,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ibm_pkg::BLK_W-1:0]   o_phys_block,
    output logic [1:0]                  o_status,
    output logic [ibm_pkg::SZ_W-1:0]    o_file_blocks
);

    ibm_pkg::t_cfg    cfg;
    ibm_pkg::t_result res;
    ibm_pkg::t_result r_out;
    logic             res_valid;
    logic             r_ovalid;
    logic             out_free;

    // Register file for the format geometry
    ibm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer and the four memories it reads, modifies and writes back
    ibm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_inode     (i_inode),
        .i_offset    (i_offset),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register: free when empty or being drained in this cycle
    assign out_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            // drop the flag once the transfer completes
            r_ovalid <= 1'b0;
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_phys_block  = r_out.phys;
    assign o_status      = r_out.status;
    assign o_file_blocks = r_out.fblocks;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Inode block map allocator testbench
// Drives format, map read, map write and truncate requests through the
// request channel. A scoreboard with its own block map and free-list model
// predicts every result and checks each field. The APB registers are written
// only while the unit is idle.
// ---------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES = 20_000_000;

    typedef struct {
        logic [ibm_pkg::BLK_W-1:0] phys;
        ibm_pkg::t_status          status;
        logic [ibm_pkg::SZ_W-1:0]  fblocks;
    } t_map_result;

    // Scoreboard: own copy of the block map, the free list and the registers
    class map_scoreboard;
        int unsigned size_of[ibm_pkg::INODES_MAX];
        int unsigned slot_ptr[ibm_pkg::IP_DEPTH];
        int unsigned ptr_mem[ibm_pkg::PS_DEPTH];
        int unsigned link_mem[ibm_pkg::DISK_BLOCKS_MAX];
        int unsigned head, head_fill, meta_blocks, disk_cfg, inode_cfg;
        t_map_result pending[$];
        int errors;

        function new();
            foreach (size_of[k]) size_of[k] = 0;
            foreach (slot_ptr[k]) slot_ptr[k] = 0;
            foreach (ptr_mem[k]) ptr_mem[k] = 0;
            foreach (link_mem[k]) link_mem[k] = 0;
            head = ibm_pkg::DISK_BLOCKS_MAX;
            head_fill = 0;
            meta_blocks = 0;
            disk_cfg = 1024;
            inode_cfg = 16;
            errors = 0;
        endfunction

        function void write_reg(ibm_pkg::t_reg_idx idx, int unsigned val);
            if (idx == ibm_pkg::REG_DISK_BLOCKS) disk_cfg = val & 11'h7FF;
            else inode_cfg = val & 9'h1FF;
        endfunction

        function int unsigned pget(int unsigned blk, int unsigned slot);
            longint unsigned a;
            a = longint'(blk) * ibm_pkg::PTRS_PER_BLOCK + slot;
            return (a < ibm_pkg::PS_DEPTH) ? ptr_mem[a] : 0;
        endfunction

        function void pset(int unsigned blk, int unsigned slot, int unsigned v);
            longint unsigned a;
            a = longint'(blk) * ibm_pkg::PTRS_PER_BLOCK + slot;
            if (a < ibm_pkg::PS_DEPTH) ptr_mem[a] = v;
        endfunction

        function longint unsigned span_of(int unsigned d);
            return longint'(1) << (4 * d);
        endfunction

        // depth 0 direct, 1..3 indirect, -1 beyond the mappable range
        function int depth_of(int unsigned off, output longint unsigned rel);
            longint unsigned o, span;
            o = off;
            span = ibm_pkg::PTRS_PER_BLOCK;
            rel = 0;
            if (o < ibm_pkg::DIRECT_PTRS) begin
                rel = o;
                return 0;
            end
            o -= ibm_pkg::DIRECT_PTRS;
            for (int d = 1; d <= 3; d++) begin
                if (o < span) begin
                    rel = o;
                    return d;
                end
                o -= span;
                span *= ibm_pkg::PTRS_PER_BLOCK;
            end
            return -1;
        endfunction

        function bit take_block(output int unsigned blk);
            blk = 0;
            if (head >= ibm_pkg::DISK_BLOCKS_MAX) return 0;
            if (head_fill > 0) begin
                head_fill--;
                blk = pget(head, head_fill);
            end else begin
                blk = head;
                head = link_mem[head];
                head_fill = ibm_pkg::FREE_PTRS;
            end
            return 1;
        endfunction

        function void give_block(int unsigned blk);
            if (blk >= ibm_pkg::DISK_BLOCKS_MAX) return;
            if (head < ibm_pkg::DISK_BLOCKS_MAX && head_fill < ibm_pkg::FREE_PTRS) begin
                pset(head, head_fill, blk);
                head_fill++;
            end else begin
                link_mem[blk] = head;
                head = blk;
                head_fill = 0;
            end
        endfunction

        function int unsigned lookup(int unsigned ino, int unsigned off);
            longint unsigned rel;
            int unsigned base, node;
            int d;
            base = ino * ibm_pkg::SLOTS_PER_INODE;
            d = depth_of(off, rel);
            if (d < 0) return 0;
            if (d == 0) return slot_ptr[base + rel];
            node = slot_ptr[base + ibm_pkg::DIRECT_PTRS + d - 1];
            for (int lv = 0; lv < d; lv++)
                node = pget(node, (rel / span_of(d - 1 - lv)) % ibm_pkg::PTRS_PER_BLOCK);
            return node;
        endfunction

        function bit grow_one(int unsigned ino, int unsigned idx);
            longint unsigned rel, below;
            int unsigned base, node, nb, digit;
            int d;
            base = ino * ibm_pkg::SLOTS_PER_INODE;
            d = depth_of(idx, rel);
            if (d < 0) return 0;
            if (d == 0) begin
                if (!take_block(nb)) return 0;
                slot_ptr[base + rel] = nb;
                return 1;
            end
            if (rel == 0) begin
                if (!take_block(nb)) return 0;
                slot_ptr[base + ibm_pkg::DIRECT_PTRS + d - 1] = nb;
            end
            node = slot_ptr[base + ibm_pkg::DIRECT_PTRS + d - 1];
            for (int lv = 0; lv < d; lv++) begin
                below = span_of(d - 1 - lv);
                digit = (rel / below) % ibm_pkg::PTRS_PER_BLOCK;
                if (lv + 1 < d) begin
                    if (rel % below == 0) begin
                        if (!take_block(nb)) return 0;
                        pset(node, digit, nb);
                    end
                    node = pget(node, digit);
                end else begin
                    if (!take_block(nb)) return 0;
                    pset(node, digit, nb);
                end
            end
            return 1;
        endfunction

        function void release_all(int unsigned ino);
            longint unsigned rel;
            int unsigned base, sz;
            int unsigned nodes[4];
            int d;
            base = ino * ibm_pkg::SLOTS_PER_INODE;
            sz = size_of[ino];
            for (int unsigned i = 0; i < sz; i++) begin
                d = depth_of(i, rel);
                if (d < 0) break;
                if (d == 0) begin
                    give_block(slot_ptr[base + i]);
                    continue;
                end
                nodes[0] = slot_ptr[base + ibm_pkg::DIRECT_PTRS + d - 1];
                for (int lv = 0; lv < d; lv++)
                    nodes[lv + 1] = pget(nodes[lv],
                        (rel / span_of(d - 1 - lv)) % ibm_pkg::PTRS_PER_BLOCK);
                give_block(nodes[d]);
                for (int lv = d - 1; lv >= 0; lv--) begin
                    if ((rel + 1) % span_of(d - lv) != 0 && i + 1 != sz) break;
                    give_block(nodes[lv]);
                end
            end
            size_of[ino] = 0;
        endfunction

        function void lay_out_store();
            int unsigned ic, db, nib, nd, r;
            if (meta_blocks != 0) return;
            ic = inode_cfg;
            db = disk_cfg;
            if (ic < 1) ic = 1;
            if (ic > ibm_pkg::INODES_MAX) ic = ibm_pkg::INODES_MAX;
            if (db > ibm_pkg::DISK_BLOCKS_MAX) db = ibm_pkg::DISK_BLOCKS_MAX;
            nib = (ic + ibm_pkg::INODES_PER_META - 1) / ibm_pkg::INODES_PER_META;
            nd = (db > nib + 1) ? db - nib - 1 : 0;
            meta_blocks = nib;
            foreach (size_of[k]) size_of[k] = 0;
            if (nd == 0) begin
                head = ibm_pkg::DISK_BLOCKS_MAX;
                head_fill = ibm_pkg::FREE_PTRS;
                return;
            end
            r = nd % (ibm_pkg::FREE_PTRS + 1);
            if (r == 0) r = ibm_pkg::FREE_PTRS + 1;
            for (int unsigned j = 0; j + 1 < r; j++) pset(0, j, j + 1);
            link_mem[0] = (nd > r) ? r : ibm_pkg::DISK_BLOCKS_MAX;
            head = 0;
            head_fill = r - 1;
            for (int unsigned m = r; m < nd; m += ibm_pkg::FREE_PTRS + 1) begin
                for (int unsigned j = 0; j < ibm_pkg::FREE_PTRS; j++) pset(m, j, m + j + 1);
                link_mem[m] = (m + ibm_pkg::FREE_PTRS + 1 < nd) ? m + ibm_pkg::FREE_PTRS + 1
                                                                : ibm_pkg::DISK_BLOCKS_MAX;
            end
        endfunction

        // Note an accepted request: update the model and queue its result
        function void note_request(ibm_pkg::t_action act, int unsigned ino, int unsigned off);
            t_map_result res;
            longint unsigned rel;
            int unsigned save_head, save_fill;
            bit in_range;
            res.phys = '0;
            res.status = ibm_pkg::ST_OK;
            res.fblocks = '0;
            in_range = ino < meta_blocks * ibm_pkg::INODES_PER_META;
            if (act == ibm_pkg::ACT_FORMAT) begin
                lay_out_store();
                in_range = ino < meta_blocks * ibm_pkg::INODES_PER_META;
            end else if (!in_range) begin
                res.status = ibm_pkg::ST_BAD_INODE;
            end else if (act == ibm_pkg::ACT_READ) begin
                if (off >= size_of[ino]) res.status = ibm_pkg::ST_BEYOND;
                else res.phys = ibm_pkg::BLK_W'(lookup(ino, off) + 1 + meta_blocks);
            end else if (act == ibm_pkg::ACT_WRITE) begin
                if (depth_of(off, rel) < 0) begin
                    res.status = ibm_pkg::ST_BEYOND;
                end else begin
                    if (off >= size_of[ino]) begin
                        save_head = head;
                        save_fill = head_fill;
                        for (int unsigned i = size_of[ino]; i <= off; i++) begin
                            if (!grow_one(ino, i)) begin
                                head = save_head;
                                head_fill = save_fill;
                                res.status = ibm_pkg::ST_NO_SPACE;
                                break;
                            end
                        end
                        if (res.status == ibm_pkg::ST_OK) size_of[ino] = off + 1;
                    end
                    if (res.status == ibm_pkg::ST_OK)
                        res.phys = ibm_pkg::BLK_W'(lookup(ino, off) + 1 + meta_blocks);
                end
            end else begin
                release_all(ino);
            end
            if (in_range) res.fblocks = ibm_pkg::SZ_W'(size_of[ino]);
            pending.push_back(res);
        endfunction

        function void check_result(logic [ibm_pkg::BLK_W-1:0] phys, logic [1:0] status,
                                   logic [ibm_pkg::SZ_W-1:0] fblocks);
            t_map_result exp_res;
            if (pending.size() == 0) begin
                $error("unexpected result: phys_block %0d status %0d", phys, status);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (phys !== exp_res.phys) begin
                $error("phys_block: expected %0d, actual %0d", exp_res.phys, phys);
                errors++;
            end
            if (status !== exp_res.status) begin
                $error("status: expected %0d, actual %0d", exp_res.status, status);
                errors++;
            end
            if (fblocks !== exp_res.fblocks) begin
                $error("file_blocks: expected %0d, actual %0d", exp_res.fblocks, fblocks);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel, penable, pwrite;
    logic [2:0]                  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        i_valid, o_ready;
    logic [1:0]                  i_action;
    logic [ibm_pkg::INO_W-1:0]   i_inode;
    logic [ibm_pkg::OFF_W-1:0]   i_offset;
    logic                        o_valid, i_ready;
    logic [ibm_pkg::BLK_W-1:0]   o_phys_block;
    logic [1:0]                  o_status;
    logic [ibm_pkg::SZ_W-1:0]    o_file_blocks;

    map_scoreboard sb = new();
    int unsigned cycles = 0;
    int unsigned phase = 0;     // 0: sender eager, receiver busy; 1: swapped; 2: no idling
    int unsigned results_seen = 0;

    inode_block_map_allocator_unit DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle counter and hard limit on the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check each transfer, then choose ready for the next edge.
    // Once, in the last phase, hold off for a long stretch so the unit backs up.
    initial begin
        bit held;
        held = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_result(o_phys_block, o_status, o_file_blocks);
                results_seen++;
            end
            if (!held && phase == 2 && results_seen > 560) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            if (phase == 0) i_ready <= ($urandom_range(99) >= 88);
            else if (phase == 1) i_ready <= ($urandom_range(99) >= 9);
            else i_ready <= 1'b1;
        end
    end

    task automatic apb_write(ibm_pkg::t_reg_idx idx, int unsigned val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold until every queued result has come back
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offer one request and hold it until the transfer
    task automatic send(ibm_pkg::t_action act, int unsigned ino, int unsigned off);
        i_valid  <= 1'b1;
        i_action <= act;
        i_inode  <= ibm_pkg::INO_W'(ino);
        i_offset <= ibm_pkg::OFF_W'(off);
        do @(posedge i_clk); while (!(o_ready && i_valid));
        sb.note_request(act, ino, off);
        // drop valid for a random gap, now and then in phase 0 and mostly in the lazy-sender phase 1
        if ((phase == 0 && $urandom_range(99) < 9) || (phase == 1 && $urandom_range(99) < 88)) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic random_request();
        int unsigned pick, ino, off;
        ibm_pkg::t_action act;
        pick = $urandom_range(99);
        if (pick < 42) act = ibm_pkg::ACT_WRITE;
        else if (pick < 82) act = ibm_pkg::ACT_READ;
        else if (pick < 96) act = ibm_pkg::ACT_TRUNC;
        else act = ibm_pkg::ACT_FORMAT;
        ino = ($urandom_range(99) < 85) ? $urandom_range(19) : $urandom_range(255);
        pick = $urandom_range(99);
        if (pick < 70) off = $urandom_range(40);
        else if (pick < 92) off = $urandom_range(300);
        else off = $urandom_range(8191);
        send(act, ino, off);
    endtask

    initial begin
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_valid  = 1'b0;
        i_action = ibm_pkg::ACT_READ;
        i_inode  = '0;
        i_offset = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register extremes first; only the last setting before format counts
        apb_write(ibm_pkg::REG_DISK_BLOCKS, 3);
        apb_write(ibm_pkg::REG_INODE_COUNT, 256);
        apb_write(ibm_pkg::REG_DISK_BLOCKS, 2047);
        apb_write(ibm_pkg::REG_INODE_COUNT, 0);
        apb_write(ibm_pkg::REG_DISK_BLOCKS, 400);
        apb_write(ibm_pkg::REG_INODE_COUNT, 20);

        // Unformatted store: every inode is out of range
        send(ibm_pkg::ACT_READ, 0, 0);
        send(ibm_pkg::ACT_WRITE, 0, 5);
        send(ibm_pkg::ACT_TRUNC, 255, 8191);
        send(ibm_pkg::ACT_FORMAT, 255, 0);
        send(ibm_pkg::ACT_FORMAT, 0, 0);        // already formatted: no change
        send(ibm_pkg::ACT_READ, 0, 0);          // empty file: beyond size
        send(ibm_pkg::ACT_WRITE, 0, 0);
        send(ibm_pkg::ACT_WRITE, 0, 11);        // last direct pointer
        send(ibm_pkg::ACT_WRITE, 0, 12);        // first single indirect
        send(ibm_pkg::ACT_WRITE, 0, 27);        // last single indirect
        send(ibm_pkg::ACT_WRITE, 0, 28);        // first double indirect
        send(ibm_pkg::ACT_READ, 0, 27);
        send(ibm_pkg::ACT_WRITE, 1, 284);       // first triple indirect
        send(ibm_pkg::ACT_READ, 1, 283);
        send(ibm_pkg::ACT_WRITE, 2, 4379);      // largest file: out of space
        send(ibm_pkg::ACT_WRITE, 2, 4380);      // beyond largest file
        send(ibm_pkg::ACT_WRITE, 19, 8191);
        send(ibm_pkg::ACT_READ, 20, 0);         // first inode out of range
        send(ibm_pkg::ACT_READ, 19, 0);
        send(ibm_pkg::ACT_TRUNC, 1, 0);
        send(ibm_pkg::ACT_TRUNC, 1, 0);         // truncate of an empty file
        send(ibm_pkg::ACT_READ, 1, 0);
        send(ibm_pkg::ACT_TRUNC, 0, 0);
        send(ibm_pkg::ACT_WRITE, 3, 8191 & 4095);

        for (int n = 0; n < 750; n++) begin
            if (n == 250 || n == 500) begin
                drain();
                phase = n / 250;
                apb_write(ibm_pkg::REG_DISK_BLOCKS, (phase == 1) ? 1024 : 3);
                apb_write(ibm_pkg::REG_INODE_COUNT, (phase == 1) ? 1 : 511);
            end
            random_request();
        end
        drain();
        repeat (50) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
